@@ hw/rtl/lzss_pkg.sv @@
// Shared types and constants of the LZSS window decoder.
package lzss_pkg;

    localparam int WINDOW_DEFAULT = 4096;
    localparam int COUNT_DEFAULT  = 24;
    localparam int LEN_BITS       = 24;
    localparam int START_POS      = 'hfee;
    localparam int MIN_MATCH      = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_LIT   = 2'd1,
        K_MATCH = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       eos;
    } t_cmd;

endpackage

@@ hw/rtl/lzss_window_decoder.sv @@
// Top level of the LZSS window decoder: config register, front end, queue, copy engine.
// Compressed bytes enter on the input channel (i_in_valid, o_in_stall) with
// i_data_byte and i_end_of_stream. Decoded bytes leave on the output channel
// (o_out_valid, i_out_stall) with o_out_byte, o_run_last and o_stream_done.
// The expected output length is written on the configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_data), which is always ready; write it only
// while the block is idle.
// The front end takes one item per cycle while the four-entry command queue
// has room; flag bytes leave no command unless they end the stream.
// The copy engine produces one byte per cycle while it has a command and the output
// is not stalled: a literal gives one byte, a match 3 to 18, one window read per byte.
// A literal passes the queue, the command and read stages and the output register.
// After reset and at each stream end the window reads as zero at once: a fill
// count marks which entries this stream has written, so no clearing pass runs.
// When the receiver stalls, the output register holds its item, the copy
// engine waits, the queue fills and o_in_stall rises.
module lzss_window_decoder #(
    parameter int WINDOW_SIZE = lzss_pkg::WINDOW_DEFAULT,
    parameter int COUNT_BITS  = lzss_pkg::COUNT_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_stream,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_run_last,
    output logic                          o_stream_done,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lzss_pkg::LEN_BITS-1:0] i_cfg_data
);

    logic [lzss_pkg::LEN_BITS-1:0] r_out_length;
    logic                          q_full;
    logic                          q_valid;
    logic                          q_push;
    logic                          q_pop;
    lzss_pkg::t_cmd                push_cmd;
    lzss_pkg::t_cmd                head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_length <= lzss_pkg::LEN_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_out_length <= i_cfg_data;
        end
    end

    lzss_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_cmd           (push_cmd)
    );

    lzss_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    lzss_back #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_out_length  (r_out_length),
        .i_q_valid     (q_valid),
        .i_q_cmd       (head_cmd),
        .o_q_pop       (q_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_stream_done (o_stream_done)
    );

endmodule

@@ hw/rtl/lzss_front.sv @@
// Front end: parses flag, literal and match bytes into commands.
module lzss_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_stream,
    input  logic              i_q_full,
    output logic              o_push,
    output lzss_pkg::t_cmd    o_cmd
);

    logic [8:0] r_flag, n_flag;
    logic       r_hi, n_hi;
    logic [7:0] r_off, n_off;
    logic       accept;
    logic       push;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign o_push     = accept && push;

    always_comb begin
        n_flag     = r_flag;
        n_hi       = r_hi;
        n_off      = r_off;
        push       = 1'b0;
        o_cmd.kind = lzss_pkg::K_NONE;
        o_cmd.b1   = i_data_byte;
        o_cmd.b2   = i_data_byte;
        o_cmd.eos  = i_end_of_stream;
        if (r_hi) begin
            o_cmd.kind = lzss_pkg::K_MATCH;
            o_cmd.b1   = r_off;
            push       = 1'b1;
            n_hi       = 1'b0;
        end else if (r_flag <= 9'd1) begin
            n_flag = {1'b1, i_data_byte};
            push   = i_end_of_stream;
        end else begin
            n_flag = r_flag >> 1;
            if (r_flag[0]) begin
                o_cmd.kind = lzss_pkg::K_LIT;
                push       = 1'b1;
            end else begin
                n_off = i_data_byte;
                n_hi  = 1'b1;
                push  = i_end_of_stream;
            end
        end
        if (i_end_of_stream) begin
            n_flag = '0;
            n_hi   = 1'b0;
            n_off  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= '0;
            r_hi   <= 1'b0;
            r_off  <= '0;
        end else if (accept) begin
            r_flag <= n_flag;
            r_hi   <= n_hi;
            r_off  <= n_off;
        end
    end

endmodule

@@ hw/rtl/lzss_cmdq.sv @@
// Short command queue between the front end and the copy engine.
module lzss_cmdq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lzss_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output lzss_pkg::t_cmd    o_cmd
);

    lzss_pkg::t_cmd                   r_mem [lzss_pkg::QUEUE_DEPTH];
    logic [lzss_pkg::QUEUE_AW-1:0]    r_wp;
    logic [lzss_pkg::QUEUE_AW-1:0]    r_rp;
    logic [lzss_pkg::QUEUE_AW:0]      r_cnt;

    assign o_full  = (r_cnt == (lzss_pkg::QUEUE_AW + 1)'(lzss_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/lzss_back.sv @@
// Copy engine: expands commands into bytes through the window memory.
module lzss_back #(
    parameter int WINDOW_SIZE = lzss_pkg::WINDOW_DEFAULT,
    parameter int COUNT_BITS  = lzss_pkg::COUNT_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lzss_pkg::LEN_BITS-1:0] i_out_length,
    input  logic                          i_q_valid,
    input  lzss_pkg::t_cmd                i_q_cmd,
    output logic                          o_q_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [7:0]                    o_out_byte,
    output logic                          o_run_last,
    output logic                          o_stream_done
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int CW = (COUNT_BITS > lzss_pkg::LEN_BITS) ? COUNT_BITS : lzss_pkg::LEN_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [AW-1:0] START = AW'(lzss_pkg::START_POS);
    localparam logic [AW:0] FILL_MAX = (AW + 1)'(WINDOW_SIZE);

    logic [7:0]            r_win [WINDOW_SIZE];

    logic                  r_a_valid;
    lzss_pkg::t_cmd        r_a_cmd;
    logic [4:0]            r_a_idx;

    logic                  r_b_valid;
    logic                  r_b_emit;
    logic                  r_b_match;
    logic [7:0]            r_b_lit;
    logic                  r_b_last;
    logic                  r_b_eos;
    logic [7:0]            r_rd_data;
    logic                  r_rd_ok;
    logic                  r_fwd;
    logic [7:0]            r_fwd_data;

    logic                  r_ov;
    logic [7:0]            r_ob;
    logic                  r_rl;
    logic                  r_done;

    logic [AW-1:0]         r_wpos;
    logic [AW:0]           r_fill;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_fin;

    logic                  adv;
    logic                  a_last;
    logic [4:0]            a_len;
    logic                  issue;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         rd_diff;
    logic                  rd_in;
    logic                  emit;
    logic                  we;
    logic                  rearm;
    logic [7:0]            byte_b;
    logic [COUNT_BITS-1:0] n_cnt;
    logic                  fin_new;

    assign adv     = !r_ov || !i_out_stall;
    assign a_len   = 5'(r_a_cmd.b2[3:0]) + 5'(lzss_pkg::MIN_MATCH);
    assign a_last  = (r_a_cmd.kind != lzss_pkg::K_MATCH) || ((r_a_idx + 5'd1) == a_len);
    assign issue   = adv && r_a_valid;
    assign o_q_pop = i_q_valid && (!r_a_valid || (issue && a_last));

    assign rd_addr = AW'({r_a_cmd.b2[7:4], r_a_cmd.b1}) + AW'(r_a_idx);
    assign rd_diff = rd_addr - START;
    assign rd_in   = ({1'b0, rd_diff} < r_fill);

    assign byte_b  = r_b_match ? (r_fwd ? r_fwd_data : (r_rd_ok ? r_rd_data : 8'd0)) : r_b_lit;
    assign emit    = r_b_valid && r_b_emit && !r_fin;
    assign we      = adv && emit;
    assign rearm   = adv && r_b_valid && r_b_eos;
    assign n_cnt   = (r_cnt == CMAX) ? r_cnt : r_cnt + 1'b1;
    assign fin_new = (CW'(n_cnt) >= CW'(i_out_length)) || (n_cnt == CMAX);

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_ob;
    assign o_run_last    = r_rl;
    assign o_stream_done = r_done;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_win[r_wpos] <= byte_b;
        end
        if (issue) begin
            r_rd_data <= r_win[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_cmd <= i_q_cmd;
        end
        if (adv) begin
            r_b_emit   <= (r_a_cmd.kind != lzss_pkg::K_NONE);
            r_b_match  <= (r_a_cmd.kind == lzss_pkg::K_MATCH);
            r_b_lit    <= r_a_cmd.b1;
            r_b_last   <= a_last;
            r_b_eos    <= a_last && r_a_cmd.eos;
            r_rd_ok    <= rd_in && !rearm;
            r_fwd      <= we && (r_wpos == rd_addr) && !rearm;
            r_fwd_data <= byte_b;
        end
        if (we) begin
            r_ob   <= byte_b;
            r_rl   <= r_b_last || fin_new;
            r_done <= fin_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_idx   <= '0;
            r_b_valid <= 1'b0;
            r_ov      <= 1'b0;
            r_wpos    <= START;
            r_fill    <= '0;
            r_cnt     <= '0;
            r_fin     <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_a_valid <= 1'b1;
                r_a_idx   <= '0;
            end else if (issue && a_last) begin
                r_a_valid <= 1'b0;
            end else if (issue) begin
                r_a_idx <= r_a_idx + 5'd1;
            end
            if (adv) begin
                r_b_valid <= r_a_valid;
                r_ov      <= emit;
            end
            if (we) begin
                r_wpos <= r_wpos + 1'b1;
                if (r_fill != FILL_MAX) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_cnt <= n_cnt;
                r_fin <= fin_new;
            end
            if (rearm) begin
                r_wpos <= START;
                r_fill <= '0;
                r_cnt  <= '0;
                r_fin  <= 1'b0;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("Window fill count exceeds the window size.");

    a_rearm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rearm |=> (r_cnt == '0) && !r_fin && (r_fill == '0) && (r_wpos == START))
        else $error("Stream end did not rearm the copy engine.");

    a_finish_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fin) |-> (r_ov && r_done && r_rl))
        else $error("Finishing byte was not marked as the last of the stream.");

    a_no_emit_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin && !rearm) |=> ($past(adv) ? !r_ov : 1'b1))
        else $error("A byte was emitted after the stream finished.");

endmodule

@@ tb/lzss_decode_checker.sv @@
// Checker for the LZSS window decoder: predicts decoded bytes and compares them at the output.
module lzss_decode_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_stream,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [7:0]                    i_out_byte,
    input  logic                          i_run_last,
    input  logic                          i_stream_done,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [lzss_pkg::LEN_BITS-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_decoded_items,
    output int                            o_checked_bytes
);

    typedef enum logic {
        WANT_TOKEN,
        WANT_MATCH_HI
    } t_token_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } t_byte_rec;

    t_byte_rec                     expected_bytes[$];
    logic [7:0]                    window_mem[0:lzss_pkg::WINDOW_DEFAULT-1];
    logic [11:0]                   wr_pos;
    logic [8:0]                    flag_bits;
    t_token_phase                  token_phase;
    logic [7:0]                    match_lo;
    logic [23:0]                   emitted;
    logic                          finished;
    logic [lzss_pkg::LEN_BITS-1:0] out_len;

    task automatic rearm();
        for (int i = 0; i < lzss_pkg::WINDOW_DEFAULT; i++) begin
            window_mem[i] = 8'h00;
        end
        wr_pos      = 12'(lzss_pkg::START_POS);
        flag_bits   = 9'd0;
        token_phase = WANT_TOKEN;
        match_lo    = 8'h00;
        emitted     = 24'd0;
        finished    = 1'b0;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s on output byte %0d: expected %0h, got %0h",
                 field, o_checked_bytes, want, got);
        o_fail_count++;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        t_byte_rec rec;
        window_mem[wr_pos] = b;
        wr_pos = wr_pos + 12'd1;
        if (emitted != 24'hffffff) begin
            emitted = emitted + 24'd1;
        end
        if (emitted >= out_len || emitted == 24'hffffff) begin
            finished = 1'b1;
        end
        rec.data = b;
        rec.last = 1'b0;
        rec.done = finished;
        expected_bytes.push_back(rec);
    endtask

    task automatic decode_item(input logic [7:0] b, input logic eos);
        logic [11:0] off;
        int          len;
        int          made;
        int          i;
        t_byte_rec   rec;
        made = 0;
        o_decoded_items++;
        if (!finished) begin
            if (token_phase == WANT_MATCH_HI) begin
                off = {b[7:4], match_lo};
                len = int'(b[3:0]) + lzss_pkg::MIN_MATCH;
                token_phase = WANT_TOKEN;
                for (i = 0; i < len && !finished; i++) begin
                    emit_byte(window_mem[off + 12'(i)]);
                    made++;
                end
            end else if (flag_bits <= 9'd1) begin
                flag_bits = {1'b1, b};
                token_phase = WANT_TOKEN;
            end else begin
                if (flag_bits[0]) begin
                    token_phase = WANT_TOKEN;
                    emit_byte(b);
                    made++;
                end else begin
                    match_lo = b;
                    token_phase = WANT_MATCH_HI;
                end
                flag_bits = flag_bits >> 1;
            end
        end
        if (made > 0) begin
            rec = expected_bytes.pop_back();
            rec.last = 1'b1;
            expected_bytes.push_back(rec);
        end
        if (eos) begin
            rearm();
        end
    endtask

    always @(posedge i_clk) begin
        t_byte_rec rec;
        if (!i_rst_n) begin
            expected_bytes.delete();
            out_len = 24'd1;
            rearm();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected byte", 32'd0, 32'(i_out_byte));
                end else begin
                    rec = expected_bytes.pop_front();
                    if (i_out_byte !== rec.data) begin
                        report_mismatch("out_byte", 32'(rec.data), 32'(i_out_byte));
                    end
                    if (i_run_last !== rec.last) begin
                        report_mismatch("run_last", 32'(rec.last), 32'(i_run_last));
                    end
                    if (i_stream_done !== rec.done) begin
                        report_mismatch("stream_done", 32'(rec.done), 32'(i_stream_done));
                    end
                end
                o_checked_bytes++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                out_len = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                decode_item(i_data_byte, i_end_of_stream);
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the LZSS window decoder testbench: clock, reset, stimulus and verdict.
module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 230;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [7:0]                    in_data   = 8'h00;
    logic                          in_eos    = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [7:0]                    out_byte;
    logic                          run_last;
    logic                          stream_done;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [lzss_pkg::LEN_BITS-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int decoded_items;
    int checked_bytes;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int cycle_count  = 0;
    int streams_sent = 0;

    logic [7:0] stream_bytes[$];

    lzss_window_decoder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_data_byte    (in_data),
        .i_end_of_stream(in_eos),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (out_byte),
        .o_run_last     (run_last),
        .o_stream_done  (stream_done),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    lzss_decode_checker checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_data_byte    (in_data),
        .i_end_of_stream(in_eos),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_byte     (out_byte),
        .i_run_last     (run_last),
        .i_stream_done  (stream_done),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_decoded_items(decoded_items),
        .o_checked_bytes(checked_bytes)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d bytes outstanding.",
                     cycle_count, pending);
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < out_idle_pct);
    end

    task automatic send_item(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        in_eos   <= eos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [lzss_pkg::LEN_BITS-1:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0]                    flags;
        logic [11:0]                   pos;
        logic [11:0]                   off;
        logic [3:0]                    len_code;
        logic [lzss_pkg::LEN_BITS-1:0] new_length;
        int                            tokens;
        int                            t;
        int                            k;
        int                            kind;
        int                            keep;
        int                            base;
        int                            phase;
        bit                            phase_start;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset length of one: the literal finishes the stream, the rest is ignored.
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'haa, 1'b0);
        send_item(8'h55, 1'b1);

        // Zero length finishes after the first byte.
        write_length('0);
        send_item(8'h01, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h3c, 1'b1);

        // Longest match over its own output, then an overlapping copy of a literal.
        write_length('1);
        send_item(8'h02, 1'b0);
        send_item(8'hee, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h7f, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h33, 1'b1);
        streams_sent = 3;

        // A match cut off by the end of the stream, then a flag byte ending a stream.
        send_item(8'h00, 1'b0);
        send_item(8'h12, 1'b1);
        send_item(8'h5a, 1'b1);
        send_item(8'hff, 1'b0);
        send_item(8'hc3, 1'b1);
        streams_sent += 3;

        base = decoded_items;
        for (phase = 0; phase < 3; phase++) begin
            in_idle_pct  = (phase == 0) ? 12 : (phase == 1) ? 60 : 0;
            out_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 12 : 0;
            phase_start  = 1'b1;
            while (decoded_items < base + RANDOM_ITEMS * (phase + 1) / 3) begin
                if (phase_start || $urandom_range(9) < 4) begin
                    case ($urandom_range(9))
                        0:       new_length = '0;
                        1:       new_length = 24'd1;
                        2:       new_length = '1;
                        3, 4, 5: new_length = 24'($urandom_range(2, 20));
                        default: new_length = 24'($urandom_range(30, 300));
                    endcase
                    write_length(new_length);
                    phase_start = 1'b0;
                end

                stream_bytes.delete();
                kind = $urandom_range(99);
                if (kind < 15) begin
                    repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom));
                end else begin
                    tokens = $urandom_range(1, 24);
                    pos = 12'(lzss_pkg::START_POS);
                    for (t = 0; t < tokens; t++) begin
                        if (t % 8 == 0) begin
                            flags = 8'($urandom);
                            stream_bytes.push_back(flags);
                        end
                        if (flags[t % 8]) begin
                            stream_bytes.push_back(8'($urandom));
                            pos = pos + 12'd1;
                        end else begin
                            if ($urandom_range(3) == 0) begin
                                off = 12'($urandom);
                            end else begin
                                off = pos - 12'($urandom_range(1, 20));
                            end
                            len_code = 4'($urandom);
                            stream_bytes.push_back(off[7:0]);
                            stream_bytes.push_back({off[11:8], len_code});
                            pos = pos + 12'(len_code) + 12'd3;
                        end
                    end
                    if (kind < 30) begin
                        keep = $urandom_range(1, stream_bytes.size());
                        while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
                    end
                end

                for (k = 0; k < stream_bytes.size(); k++) begin
                    send_item(stream_bytes[k], k == stream_bytes.size() - 1);
                end
                streams_sent++;
                if ($urandom_range(9) == 0) begin
                    wait_for_drain();
                end
            end
        end

        wait_for_drain();
        $display("Decoded %0d compressed bytes into %0d checked output bytes over %0d streams.",
                 decoded_items, checked_bytes, streams_sent);
        $display("Lengths included zero, one and the maximum; stalls ran in three mixes.");
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
